FILE: hdl/gregorian_date_add_days_core_defines.svh
// Assertion macros for the checker file of the date adder.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gda_pkg.sv
// Shared types, constants and calendar tables of the date adder.
package gda_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OFFSET_W    = 16;
    localparam int OFFSET_USE  = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam logic [OFFSET_W-1:0] OFFSET_MASK =
        OFFSET_W'((17'd1 << OFFSET_USE) - 17'd1);

    // Accumulator holds offset plus a day of year.
    localparam int ACC_W = OFFSET_W + 1;

    localparam logic [13:0] MAX_YEAR = 14'd9999;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] offset_days;
    } in_t;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic [2:0]  weekday;
        logic        year_overflow;
    } out_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             le;
    } alu_res_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } wk_req_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (mon == 4'd2)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (mon inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            len = 5'd30;
        end
        return len;
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [2:0] sak_val(input logic [3:0] mon);
        logic [2:0] v;
        case (mon)
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd2;
            4'd4:    v = 3'd5;
            4'd5:    v = 3'd0;
            4'd6:    v = 3'd3;
            4'd7:    v = 3'd5;
            4'd8:    v = 3'd1;
            4'd9:    v = 3'd4;
            4'd10:   v = 3'd6;
            4'd11:   v = 3'd2;
            4'd12:   v = 3'd4;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/gregorian_date_add_days_core.sv
// Top level of the Gregorian date adder with weekday output.
//
//  Channel   Signals               Direction  Handshake
//  -------   -------------------   ---------  ---------------------------------
//  command   start, busy, item     in         taken when start && !busy
//  result    done, result          out        one-cycle strobe, no back pressure
//
// The sequencer walks the months before the start month, then the years crossed,
// then the months of the result year; the year loop through the shared
// add/subtract unit steps one whole year per cycle.
// Reset is asynchronous and active low; it returns the sequencer to idle.
// busy stays high from acceptance until the cycle the result strobe shows.
// The receiver cannot stall: each result is valid for exactly one cycle.
module gregorian_date_add_days_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  gda_pkg::in_t   item,
    output logic           done,
    output gda_pkg::out_t  result
);
    import gda_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_INIT2 = 4'd2;
    localparam logic [3:0] S_DOY   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_YEAR  = 4'd5;
    localparam logic [3:0] S_MON   = 4'd6;
    localparam logic [3:0] S_WK    = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic             done_reg;

    // Working registers of the sequencer.
    logic [4:0]       d_reg;
    logic [3:0]       m_reg;
    logic [13:0]      y_reg;
    logic [ACC_W-1:0] x_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [3:0]       mi_reg;
    logic [7:0]       q100_reg;
    logic [6:0]       r100_reg;
    logic [1:0]       c4_reg;
    logic             ovf_reg;
    out_t             out_reg;

    logic             accept;
    logic             leap;
    logic [4:0]       cur_mlen;
    logic [26:0]      y_prod;
    logic [13:0]      y_hund;
    logic [ACC_W-1:0] alu_b;
    logic             alu_op;
    alu_res_t         alu_res;
    wk_req_t          wk_req;
    logic             wk_go;
    logic             wk_done;
    logic [2:0]       wk_val;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // The year is tracked together with its remainder modulo 100 and the
    // low bits of its century count, so the leap test needs no divider.
    assign leap = ((y_reg[1:0] == 2'd0) && (r100_reg != 7'd0))
               || ((r100_reg == 7'd0) && (c4_reg == 2'd0));

    assign cur_mlen = month_len(mi_reg, leap);
    assign y_prod   = 27'(y_reg) * 27'd5243;
    assign y_hund   = 14'({q100_reg, 6'b0}) + 14'({q100_reg, 5'b0}) + 14'({q100_reg, 2'b0});

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_b  = ACC_W'(cur_mlen);
        case (state_reg)
            S_DOY:
            begin
                alu_op = ALU_ADD;
                alu_b  = ACC_W'(cur_mlen);
            end
            S_SUM:
            begin
                alu_op = ALU_ADD;
                alu_b  = x_reg;
            end
            S_YEAR:
            begin
                alu_op = ALU_SUB;
                alu_b  = ACC_W'(year_len(leap));
            end
            default:
            begin
                alu_op = ALU_SUB;
                alu_b  = ACC_W'(cur_mlen);
            end
        endcase
    end

    gda_alu u_alu (
        .a   (acc_reg),
        .b   (alu_b),
        .op  (alu_op),
        .res (alu_res)
    );

    assign wk_go      = (state_reg == S_WK);
    assign wk_req.day   = d_reg;
    assign wk_req.month = m_reg;
    assign wk_req.year  = y_reg;

    gda_wkday u_wkday (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (wk_go),
        .req     (wk_req),
        .done    (wk_done),
        .weekday (wk_val)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:  state_next = S_INIT2;
            S_INIT2: state_next = S_DOY;
            S_DOY:
            begin
                if (mi_reg == m_reg)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:   state_next = S_YEAR;
            S_YEAR:
            begin
                if (alu_res.le || (y_reg == MAX_YEAR))
                begin
                    state_next = alu_res.le ? S_MON : S_WK;
                end
            end
            S_MON:
            begin
                if ((mi_reg == 4'd12) || alu_res.le)
                begin
                    state_next = S_WK;
                end
            end
            S_WK:    state_next = S_WAIT;
            S_WAIT:
            begin
                if (wk_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_WAIT) && wk_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Out-of-range fields are clamped: day 0 to 1, month to 1..12, year to 1..MAX_YEAR.
                    d_reg <= (item.start_day == 5'd0) ? 5'd1 : item.start_day;
                    if (item.start_month == 4'd0)
                    begin
                        m_reg <= 4'd1;
                    end
                    else if (item.start_month > 4'd12)
                    begin
                        m_reg <= 4'd12;
                    end
                    else
                    begin
                        m_reg <= item.start_month;
                    end
                    if (item.start_year == 14'd0)
                    begin
                        y_reg <= 14'd1;
                    end
                    else if (item.start_year > MAX_YEAR)
                    begin
                        y_reg <= MAX_YEAR;
                    end
                    else
                    begin
                        y_reg <= item.start_year;
                    end
                    x_reg   <= ACC_W'(item.offset_days & OFFSET_MASK);
                    ovf_reg <= 1'b0;
                end
            end
            S_INIT:
            begin
                q100_reg <= y_prod[26:19];
            end
            S_INIT2:
            begin
                r100_reg <= 7'(y_reg - y_hund);
                c4_reg   <= q100_reg[1:0];
                acc_reg  <= ACC_W'(d_reg);
                mi_reg   <= 4'd1;
            end
            S_DOY:
            begin
                if (mi_reg != m_reg)
                begin
                    acc_reg <= alu_res.value;
                    mi_reg  <= mi_reg + 4'd1;
                end
            end
            S_SUM:
            begin
                // From here on the accumulator counts days from January 1.
                acc_reg <= alu_res.value;
            end
            S_YEAR:
            begin
                if (alu_res.le)
                begin
                    mi_reg <= 4'd1;
                end
                else if (y_reg == MAX_YEAR)
                begin
                    // Carrying past the last year saturates the date.
                    ovf_reg <= 1'b1;
                    d_reg   <= 5'd31;
                    m_reg   <= 4'd12;
                end
                else
                begin
                    acc_reg <= alu_res.value;
                    y_reg   <= y_reg + 14'd1;
                    if (r100_reg == 7'd99)
                    begin
                        r100_reg <= 7'd0;
                        c4_reg   <= c4_reg + 2'd1;
                    end
                    else
                    begin
                        r100_reg <= r100_reg + 7'd1;
                    end
                end
            end
            S_MON:
            begin
                if ((mi_reg != 4'd12) && !alu_res.le)
                begin
                    acc_reg <= alu_res.value;
                    mi_reg  <= mi_reg + 4'd1;
                end
                else
                begin
                    d_reg <= acc_reg[4:0];
                    m_reg <= mi_reg;
                end
            end
            S_WAIT:
            begin
                if (wk_done)
                begin
                    out_reg.result_day    <= d_reg;
                    out_reg.result_month  <= m_reg;
                    out_reg.result_year   <= y_reg;
                    out_reg.weekday       <= wk_val;
                    out_reg.year_overflow <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

FILE: hdl/gda_alu.sv
// Shared add and subtract unit with a less-or-equal compare.
module gda_alu (
    input  logic [gda_pkg::ACC_W-1:0] a,
    input  logic [gda_pkg::ACC_W-1:0] b,
    input  logic                      op,
    output gda_pkg::alu_res_t         res
);
    import gda_pkg::*;

    logic [ACC_W:0] diff;

    always_comb
    begin
        diff      = {1'b0, a} - {1'b0, b};
        res.le    = diff[ACC_W] | (diff[ACC_W-1:0] == '0);
        if (op == ALU_SUB)
        begin
            res.value = diff[ACC_W-1:0];
        end
        else
        begin
            res.value = a + b;
        end
    end

endmodule

FILE: hdl/gda_wkday.sv
// Four-stage weekday unit using the table method with reciprocal divides.
module gda_wkday (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  gda_pkg::wk_req_t req,
    output logic             done,
    output logic [2:0]       weekday
);
    import gda_pkg::*;

    logic [2:0]  vld_reg;
    logic        done_reg;
    logic [13:0] yy_reg;
    logic [5:0]  base_reg;
    logic [26:0] prod1_reg;
    logic [14:0] sum_reg;
    logic [30:0] prod2_reg;
    logic [2:0]  wk_reg;

    logic [13:0] yy;
    logic [7:0]  q100;
    logic [12:0] q7;
    logic [15:0] rem_full;
    logic [3:0]  rem4;

    always_comb
    begin
        yy       = (req.month < 4'd3) ? (req.year - 14'd1) : req.year;
        q100     = prod1_reg[26:19];
        q7       = prod2_reg[30:18];
        rem_full = 16'(sum_reg) - (16'({q7, 3'b000}) - 16'(q7));
        rem4     = rem_full[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], go};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            yy_reg    <= yy;
            base_reg  <= 6'(sak_val(req.month)) + 6'(req.day);
            prod1_reg <= 27'(yy) * 27'd5243;
        end
        if (vld_reg[0])
        begin
            sum_reg <= 15'(yy_reg) + 15'(yy_reg >> 2) - 15'(q100)
                     + 15'(q100 >> 2) + 15'(base_reg);
        end
        if (vld_reg[1])
        begin
            prod2_reg <= 31'(sum_reg) * 31'd37449;
        end
        if (vld_reg[2])
        begin
            // The reciprocal estimate may be one low, so fold once more.
            wk_reg <= (rem4 >= 4'd7) ? 3'(rem4 - 4'd7) : rem4[2:0];
        end
    end

    assign done    = done_reg;
    assign weekday = wk_reg;

endmodule

FILE: hdl/gda_checker.sv
// Port-level checker for the date adder, bound to its top level.
`include "gregorian_date_add_days_core_defines.svh"

module gda_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input gda_pkg::out_t result
);
    import gda_pkg::*;

    `GDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `GDA_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
    `GDA_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result strobe without a transaction")
    `GDA_ASSERT_SAME(a_ovf_saturate, done && result.year_overflow, (result.result_day == 5'd31) && (result.result_month == 4'd12) && (result.result_year == MAX_YEAR) && (result.weekday == 3'd5), "overflow result not saturated")
    `GDA_ASSERT_SAME(a_ranges, done, (result.result_month >= 4'd1) && (result.result_month <= 4'd12) && (result.result_day != 5'd0) && (result.weekday <= 3'd6), "result field out of range")

endmodule

bind gregorian_date_add_days_core gda_checker u_gda_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
